// File: hw/rtl/rfca_pkg.sv
// Shared types and constants for the auto-ranging reciprocal frequency counter.
package rfca_pkg;

    localparam int FREQ_W = 44;
    localparam int CFG_AW = 5;

    localparam logic [CFG_AW-1:0] ADDR_REF_CLOCK  = 5'd0;
    localparam logic [CFG_AW-1:0] ADDR_GATE_TICKS = 5'd4;
    localparam logic [CFG_AW-1:0] ADDR_LOW_ABORT  = 5'd8;
    localparam logic [CFG_AW-1:0] ADDR_HIGH_MIN   = 5'd12;
    localparam logic [CFG_AW-1:0] ADDR_LOW_MAX    = 5'd16;
    localparam logic [CFG_AW-1:0] ADDR_BAND       = 5'd20;

    typedef struct packed {
        logic [27:0] ref_clock_hz;
        logic [31:0] gate_ticks;
        logic [31:0] low_abort_edges;
        logic [31:0] high_min_edges;
        logic [27:0] low_max_freq_hz;
        logic [31:0] stable_band_q16;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mul_start;  // load operands, begin products
        logic mul_step;   // one partial-product step
        logic div_start;  // load dividend for the divider
        logic div_step;   // one quotient bit
        logic commit;     // apply result, run lock rule
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic below_max;
    } sts_t;

endpackage

// File: hw/rtl/rfca_ctrl.sv
// Measurement controller: gate counting, mode control and arithmetic sequencing.
module rfca_ctrl
    import rfca_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_edge,
    input  logic                   out_busy,
    output logic [COUNT_WIDTH-1:0] edges_o,
    output logic [COUNT_WIDTH-1:0] ticks_o,
    output logic                   high_o,
    output cmd_t                   cmd,
    input  sts_t                   sts
);

    localparam int DIV_STEPS = COUNT_WIDTH + 28 + FRAC_BITS;
    localparam int SC_W      = $clog2(DIV_STEPS + 1);
    localparam int MUL_STEPS = (COUNT_WIDTH + 15) / 16;

    typedef enum logic [2:0] {
        S_COUNT, S_LOAD, S_MUL, S_CHECK, S_DIV, S_DONE
    } state_t;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    state_t                 state_reg, state_next;
    logic                   mode_high_reg, mode_high_next;
    logic                   gate_active_reg, gate_active_next;
    logic                   gate_elapsed_reg, gate_elapsed_next;
    logic [COUNT_WIDTH-1:0] edge_cnt_reg, edge_cnt_next;
    logic [COUNT_WIDTH-1:0] ref_cnt_reg, ref_cnt_next;
    logic [31:0]            timer_reg, timer_next;
    logic [SC_W-1:0]        step_reg, step_next;

    logic                   acc;
    logic [COUNT_WIDTH-1:0] r_inc, e_inc;
    logic [31:0]            t_inc;

    assign in_ready = (state_reg == S_COUNT);
    assign acc      = in_valid && in_ready;
    assign edges_o  = edge_cnt_reg;
    assign ticks_o  = ref_cnt_reg;
    assign high_o   = mode_high_reg;

    assign r_inc = (ref_cnt_reg == CNT_MAX) ? ref_cnt_reg : ref_cnt_reg + 1'b1;
    assign e_inc = (edge_cnt_reg == CNT_MAX) ? edge_cnt_reg : edge_cnt_reg + 1'b1;
    assign t_inc = (timer_reg == 32'hFFFF_FFFF) ? timer_reg : timer_reg + 32'd1;

    always_comb begin
        state_next        = state_reg;
        mode_high_next    = mode_high_reg;
        gate_active_next  = gate_active_reg;
        gate_elapsed_next = gate_elapsed_reg;
        edge_cnt_next     = edge_cnt_reg;
        ref_cnt_next      = ref_cnt_reg;
        timer_next        = timer_reg;
        step_next         = step_reg;
        cmd               = '0;
        case (state_reg)
            S_COUNT: begin
                if (acc) begin
                    if (mode_high_reg) begin
                        ref_cnt_next = r_inc;
                        if (in_edge) begin
                            edge_cnt_next = e_inc;
                        end
                        timer_next = t_inc;
                        if (t_inc >= cfg.gate_ticks) begin
                            if ({{(64-COUNT_WIDTH){1'b0}}, edge_cnt_next}
                                < {32'd0, cfg.high_min_edges}) begin
                                mode_high_next    = 1'b0;
                                gate_active_next  = 1'b0;
                                edge_cnt_next     = '0;
                                ref_cnt_next      = '0;
                                timer_next        = '0;
                                gate_elapsed_next = 1'b0;
                            end else begin
                                state_next = S_LOAD;
                            end
                        end
                    end else begin
                        if (gate_active_reg) begin
                            ref_cnt_next = r_inc;
                            timer_next   = t_inc;
                            if (t_inc >= cfg.gate_ticks) begin
                                gate_elapsed_next = 1'b1;
                            end
                        end
                        if (in_edge) begin
                            if (!gate_active_reg) begin
                                gate_active_next  = 1'b1;
                                edge_cnt_next     = '0;
                                ref_cnt_next      = '0;
                                timer_next        = '0;
                                gate_elapsed_next = 1'b0;
                            end else begin
                                edge_cnt_next = e_inc;
                                if ({{(64-COUNT_WIDTH){1'b0}}, e_inc}
                                    > {32'd0, cfg.low_abort_edges}) begin
                                    mode_high_next    = 1'b1;
                                    gate_active_next  = 1'b1;
                                    edge_cnt_next     = '0;
                                    ref_cnt_next      = '0;
                                    timer_next        = '0;
                                    gate_elapsed_next = 1'b0;
                                end else if (gate_elapsed_next) begin
                                    state_next = S_LOAD;
                                end
                            end
                        end
                    end
                end
            end
            S_LOAD: begin
                cmd.mul_start = 1'b1;
                step_next     = '0;
                state_next    = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == SC_W'(MUL_STEPS - 1)) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!mode_high_reg && !sts.below_max) begin
                    mode_high_next    = 1'b1;
                    gate_active_next  = 1'b1;
                    edge_cnt_next     = '0;
                    ref_cnt_next      = '0;
                    timer_next        = '0;
                    gate_elapsed_next = 1'b0;
                    state_next        = S_COUNT;
                end else begin
                    cmd.div_start = 1'b1;
                    step_next     = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == SC_W'(DIV_STEPS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_busy) begin
                    cmd.commit        = 1'b1;
                    gate_active_next  = mode_high_reg;
                    edge_cnt_next     = '0;
                    ref_cnt_next      = '0;
                    timer_next        = '0;
                    gate_elapsed_next = 1'b0;
                    state_next        = S_COUNT;
                end
            end
            default: state_next = S_COUNT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_COUNT;
            mode_high_reg    <= 1'b0;
            gate_active_reg  <= 1'b0;
            gate_elapsed_reg <= 1'b0;
            edge_cnt_reg     <= '0;
            ref_cnt_reg      <= '0;
            timer_reg        <= '0;
            step_reg         <= '0;
        end else begin
            state_reg        <= state_next;
            mode_high_reg    <= mode_high_next;
            gate_active_reg  <= gate_active_next;
            gate_elapsed_reg <= gate_elapsed_next;
            edge_cnt_reg     <= edge_cnt_next;
            ref_cnt_reg      <= ref_cnt_next;
            timer_reg        <= timer_next;
            step_reg         <= step_next;
        end
    end

endmodule

// File: hw/rtl/rfca_dpath.sv
// Arithmetic datapath: serial products, restoring divider, lock rule and output register.
module rfca_dpath
    import rfca_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic [COUNT_WIDTH-1:0] edges_i,
    input  logic [COUNT_WIDTH-1:0] ticks_i,
    input  logic                   high_i,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FREQ_W-1:0]      out_freq,
    output logic [31:0]            out_edges,
    output logic [31:0]            out_ticks,
    output logic                   out_high,
    output logic [FREQ_W-1:0]      out_held,
    output logic                   out_locked
);

    localparam int PW     = COUNT_WIDTH + 28;
    localparam int NW     = PW + FRAC_BITS;
    localparam int MUL_ST = (COUNT_WIDTH + 15) / 16;
    localparam int EW     = MUL_ST * 16;
    localparam int AW     = EW + 28;
    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    logic [EW-1:0]          ea_reg, ta_reg;
    logic [AW-1:0]          pa_reg, pb_reg;
    logic [NW-1:0]          num_reg;
    logic [COUNT_WIDTH:0]   rem_reg;
    logic [FREQ_W-1:0]      q_reg;
    logic                   sat_reg;
    logic [COUNT_WIDTH-1:0] den;

    logic                   pair_second_reg;
    logic [FREQ_W-1:0]      pair_first_reg;
    logic [1:0]             match_reg;
    logic                   lock_reg;
    logic [FREQ_W-1:0]      held_reg;
    logic                   vld_reg;

    logic [43:0]            pe, pt;
    logic [COUNT_WIDTH:0]   r_sh, r_sub;
    logic                   q_bit;
    logic [FREQ_W-1:0]      f, diff;
    logic [1:0]             m1;
    logic                   lk1, lk2;
    logic [FREQ_W-1:0]      h1;
    logic                   pair_done;

    assign den = ticks_i;
    assign pe  = ea_reg[15:0] * cfg.ref_clock_hz;
    assign pt  = ta_reg[15:0] * cfg.low_max_freq_hz;
    assign sts.below_max = pa_reg < pb_reg;

    assign r_sh  = {rem_reg[COUNT_WIDTH-1:0], num_reg[NW-1]};
    assign r_sub = r_sh - {1'b0, den};
    assign q_bit = r_sh >= {1'b0, den};

    assign pair_done = high_i && pair_second_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            ea_reg <= EW'(edges_i);
            ta_reg <= EW'(ticks_i);
            pa_reg <= '0;
        end else if (cmd.mul_step) begin
            pa_reg <= (pa_reg >> 16) + (AW'(pe) << (EW - 16));
            ea_reg <= ea_reg >> 16;
            ta_reg <= ta_reg >> 16;
        end
        if (cmd.div_start) begin
            num_reg <= NW'(pa_reg) << FRAC_BITS;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (cmd.div_step) begin
            num_reg <= num_reg << 1;
            if (q_reg > (FREQ_MAX >> 1)) begin
                sat_reg <= 1'b1;
            end
            q_reg   <= {q_reg[FREQ_W-2:0], q_bit};
            rem_reg <= q_bit ? r_sub : r_sh;
        end
    end

    always_comb begin
        f    = (den == '0) ? '0 : (sat_reg ? FREQ_MAX : q_reg);
        diff = (f >= pair_first_reg) ? f - pair_first_reg : pair_first_reg - f;
        m1   = match_reg;
        if ({12'd0, cfg.stable_band_q16} > diff && match_reg != 2'd3) begin
            m1 = match_reg + 2'd1;
        end
        lk1 = lock_reg;
        h1  = held_reg;
        if (m1 == 2'd2 && !lock_reg) begin
            m1  = 2'd0;
            h1  = f;
            lk1 = 1'b1;
        end
        lk2 = lk1;
        if (lk1 && f > pair_first_reg && diff > {12'd0, cfg.stable_band_q16}) begin
            lk2 = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg         <= 1'b0;
            pair_second_reg <= 1'b0;
            pair_first_reg  <= '0;
            match_reg       <= '0;
            lock_reg        <= 1'b0;
            held_reg        <= '0;
        end else begin
            vld_reg <= cmd.commit || (vld_reg && !out_ready);
            if (cmd.commit) begin
                out_freq   <= f;
                out_edges  <= 32'(edges_i) | {32{|(edges_i >> 31 >> 1)}};
                out_ticks  <= 32'(ticks_i) | {32{|(ticks_i >> 31 >> 1)}};
                out_high   <= high_i;
                out_held   <= pair_done ? h1 : held_reg;
                out_locked <= pair_done ? lk2 : lock_reg;
                if (high_i) begin
                    if (!pair_second_reg) begin
                        pair_second_reg <= 1'b1;
                        pair_first_reg  <= f;
                    end else begin
                        pair_second_reg <= 1'b0;
                        match_reg       <= m1;
                        lock_reg        <= lk2;
                        held_reg        <= h1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            pb_reg <= '0;
        end else if (cmd.mul_step) begin
            pb_reg <= (pb_reg >> 16) + (AW'(pt) << (EW - 16));
        end
    end

    assign out_valid = vld_reg;

endmodule

// File: hw/rtl/reciprocal_frequency_counter_autorange_core.sv
// Top level of the auto-ranging reciprocal frequency counter with its register file.
//
// The slave stream carries one transaction per reference-clock tick; tdata bit 0 is
// the signal-edge flag. While counting, s_tready stays high. When a gate closes, the
// block stops taking transactions while it forms edges*ref_clock/ticks: a load step,
// a serial multiplier of 16 bits per cycle, a compare step (in low mode, a frequency
// at or above low_max_freq_hz switches to high mode and drops the result), a
// restoring divider of one quotient bit per cycle, then a commit step.
// The result sits in an output register on the master stream. A new gate counts
// while the result waits; if the next result is ready before the first was taken,
// the block holds s_tready low in its commit cycle until the master stream moves.
// Reset (aresetn low, synchronous) selects low mode with the gate shut, clears the
// lock, and loads the register defaults. Registers sit on the APB port at 4*index.
module reciprocal_frequency_counter_autorange_core
    import rfca_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [0] signal_edge
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [151:0]  m_tdata,   // freq_q16, edge_total, tick_total, held_freq_q16
    output logic [1:0]    m_tuser,   // [0] high_mode, [1] held_locked
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic [COUNT_WIDTH-1:0] edges, ticks;
    logic high;
    logic [FREQ_W-1:0] o_freq, o_held;
    logic [31:0] o_edges, o_ticks;
    logic o_high, o_locked;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ref_clock_hz    <= 28'd240000000;
            cfg_reg.gate_ticks      <= 32'd24000000;
            cfg_reg.low_abort_edges <= 32'd20000;
            cfg_reg.high_min_edges  <= 32'd10000;
            cfg_reg.low_max_freq_hz <= 28'd10000;
            cfg_reg.stable_band_q16 <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                ADDR_REF_CLOCK:  cfg_reg.ref_clock_hz    <= pwdata[27:0];
                ADDR_GATE_TICKS: cfg_reg.gate_ticks      <= pwdata;
                ADDR_LOW_ABORT:  cfg_reg.low_abort_edges <= pwdata;
                ADDR_HIGH_MIN:   cfg_reg.high_min_edges  <= pwdata;
                ADDR_LOW_MAX:    cfg_reg.low_max_freq_hz <= pwdata[27:0];
                ADDR_BAND:       cfg_reg.stable_band_q16 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_REF_CLOCK:  prdata = {4'd0, cfg_reg.ref_clock_hz};
            ADDR_GATE_TICKS: prdata = cfg_reg.gate_ticks;
            ADDR_LOW_ABORT:  prdata = cfg_reg.low_abort_edges;
            ADDR_HIGH_MIN:   prdata = cfg_reg.high_min_edges;
            ADDR_LOW_MAX:    prdata = {4'd0, cfg_reg.low_max_freq_hz};
            ADDR_BAND:       prdata = cfg_reg.stable_band_q16;
            default:         prdata = '0;
        endcase
    end

    rfca_ctrl #(.COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_edge(s_tdata[0]),
        .out_busy(m_tvalid && !m_tready),
        .edges_o(edges), .ticks_o(ticks), .high_o(high), .cmd(cmd), .sts(sts)
    );

    rfca_dpath #(.COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .cmd(cmd), .sts(sts),
        .edges_i(edges), .ticks_i(ticks), .high_i(high),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_freq(o_freq), .out_edges(o_edges), .out_ticks(o_ticks),
        .out_high(o_high), .out_held(o_held), .out_locked(o_locked)
    );

    assign m_tdata = {o_held, o_ticks, o_edges, o_freq};
    assign m_tuser = {o_locked, o_high};

endmodule

// File: hw/rtl/rfca_checker.sv
// Port-level checker for the frequency counter core and its bind statement.
module rfca_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,
    input logic         pready
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind reciprocal_frequency_counter_autorange_core rfca_checker u_rfca_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
